// File: rtl/adcmus_pkg.sv
// Shared constants and codes for the converter request scheduler.
`default_nettype none
package adcmus_pkg;
   localparam int NUM_USERS = 8;
   localparam int USER_W = 3;
   localparam int CHAN_W = 8;
   localparam int RATE_W = 3;
   localparam int DATA_W = 16;
   localparam int STATUS_W = 3;

   typedef enum logic [1:0] {
      REQ_START = 2'd0,
      REQ_DATA = 2'd1,
      REQ_CONV_DONE = 2'd2,
      REQ_UNKNOWN = 2'd3
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE = 3'd0,
      ST_BUSY = 3'd1,
      ST_DEFERRED = 3'd2,
      ST_NONE = 3'd3,
      ST_FATAL = 3'd4
   } status_type;

   typedef logic [NUM_USERS-1:0] user_mask_type;
endpackage
`default_nettype wire

// File: rtl/adc_multi_user_request_scheduler_top.sv
// Top level of the converter request scheduler: queue, memories and response logic.
// A transaction is taken when start is high and busy is low. The accept cycle reads
// the per-user memories into registers and the following cycle, with busy high, updates
// the queue and writes the memories back, so no new transaction is taken while the last
// one is being applied. The result appears in the cycle after busy, on the rsp_ ports
// for exactly one cycle marked by rsp_valid; it cannot be held off, and a new
// transaction may be accepted in that same cycle.
`default_nettype none
module adc_multi_user_request_scheduler_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [1:0]                      req_type,
   input  wire logic [adcmus_pkg::USER_W-1:0]   req_user_id,
   input  wire logic                            req_reference_internal,
   input  wire logic [adcmus_pkg::CHAN_W-1:0]   req_channel_select,
   input  wire logic [adcmus_pkg::RATE_W-1:0]   req_sample_rate,
   input  wire logic [adcmus_pkg::DATA_W-1:0]   req_conversion_data,
   output logic                                 rsp_valid,
   output logic [adcmus_pkg::STATUS_W-1:0]      rsp_status,
   output logic [adcmus_pkg::DATA_W-1:0]        rsp_read_value,
   output logic                                 rsp_start_conv,
   output logic [adcmus_pkg::USER_W-1:0]        rsp_start_user,
   output logic [adcmus_pkg::CHAN_W-1:0]        rsp_start_channel,
   output logic [adcmus_pkg::RATE_W-1:0]        rsp_start_rate,
   output logic                                 rsp_converter_off
);
   localparam int CFG_W = adcmus_pkg::CHAN_W + adcmus_pkg::RATE_W;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic busy_ff, busy_in;

   adcmus_pkg::user_mask_type pending_ff, pending_in;
   adcmus_pkg::user_mask_type valid_ff, valid_in;
   logic conv_busy_ff, conv_busy_in;
   logic [adcmus_pkg::USER_W-1:0] cur_user_ff, cur_user_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [adcmus_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [adcmus_pkg::DATA_W-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic rsp_start_conv_ff, rsp_start_conv_in;
   logic [adcmus_pkg::USER_W-1:0] rsp_start_user_ff, rsp_start_user_in;
   logic [adcmus_pkg::CHAN_W-1:0] rsp_start_channel_ff, rsp_start_channel_in;
   logic [adcmus_pkg::RATE_W-1:0] rsp_start_rate_ff, rsp_start_rate_in;
   logic rsp_converter_off_ff, rsp_converter_off_in;

   logic [1:0] type_ff;
   logic [adcmus_pkg::USER_W-1:0] id_ff;
   logic refi_ff;
   logic [adcmus_pkg::CHAN_W-1:0] chan_ff;
   logic [adcmus_pkg::RATE_W-1:0] rate_ff;
   logic [adcmus_pkg::DATA_W-1:0] data_ff;
   logic [adcmus_pkg::USER_W-1:0] low_ff, low_in;

   logic [adcmus_pkg::DATA_W-1:0] reading_mem [adcmus_pkg::NUM_USERS];
   logic [CFG_W-1:0] cfg_mem [adcmus_pkg::NUM_USERS];
   logic [adcmus_pkg::DATA_W-1:0] reading_rd_ff;
   logic [CFG_W-1:0] cfg_rd_ff;

   logic reading_we;
   logic [adcmus_pkg::USER_W-1:0] reading_wa;
   logic cfg_we;

   logic accept;
   logic id_bad;
   adcmus_pkg::req_kind_type kind;

   assign accept = start && !busy_ff;
   assign kind = adcmus_pkg::req_kind_type'(type_ff);
   assign id_bad = 32'(id_ff) >= adcmus_pkg::NUM_USERS;

   always_comb begin
      low_in = '0;
      for (int u = adcmus_pkg::NUM_USERS - 1; u >= 0; u--) begin
         if (pending_ff[u]) begin
            low_in = adcmus_pkg::USER_W'(u);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff <= req_type;
         id_ff <= req_user_id;
         refi_ff <= req_reference_internal;
         chan_ff <= req_channel_select;
         rate_ff <= req_sample_rate;
         data_ff <= req_conversion_data;
         low_ff <= low_in;
         reading_rd_ff <= reading_mem[req_user_id];
         cfg_rd_ff <= cfg_mem[low_in];
      end
      if (reading_we) begin
         reading_mem[reading_wa] <= data_ff;
      end
      if (cfg_we) begin
         cfg_mem[id_ff] <= {chan_ff, rate_ff};
      end
   end

   always_comb begin
      state_in = state_ff;
      busy_in = busy_ff;
      pending_in = pending_ff;
      valid_in = valid_ff;
      conv_busy_in = conv_busy_ff;
      cur_user_in = cur_user_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = adcmus_pkg::ST_NONE;
      rsp_read_value_in = '0;
      rsp_start_conv_in = 1'b0;
      rsp_start_user_in = '0;
      rsp_start_channel_in = '0;
      rsp_start_rate_in = '0;
      rsp_converter_off_in = 1'b0;
      reading_we = 1'b0;
      reading_wa = cur_user_ff;
      cfg_we = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
               busy_in = 1'b1;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            busy_in = 1'b0;
            rsp_valid_in = 1'b1;
            case (kind)
               adcmus_pkg::REQ_CONV_DONE: begin
                  if (!conv_busy_ff) begin
                     rsp_status_in = adcmus_pkg::ST_NONE;
                  end else begin
                     reading_we = 1'b1;
                     valid_in[cur_user_ff] = 1'b1;
                     rsp_status_in = adcmus_pkg::ST_DONE;
                     if (pending_ff != '0) begin
                        pending_in[low_ff] = 1'b0;
                        cur_user_in = low_ff;
                        rsp_start_conv_in = 1'b1;
                        rsp_start_user_in = low_ff;
                        rsp_start_channel_in = cfg_rd_ff[CFG_W-1:adcmus_pkg::RATE_W];
                        rsp_start_rate_in = cfg_rd_ff[adcmus_pkg::RATE_W-1:0];
                     end else begin
                        conv_busy_in = 1'b0;
                        rsp_converter_off_in = 1'b1;
                     end
                  end
               end
               adcmus_pkg::REQ_DATA: begin
                  if (id_bad) begin
                     rsp_status_in = adcmus_pkg::ST_FATAL;
                  end else if (valid_ff[id_ff]) begin
                     rsp_status_in = adcmus_pkg::ST_DONE;
                     rsp_read_value_in = reading_rd_ff;
                     valid_in[id_ff] = 1'b0;
                  end else if (pending_ff[id_ff]) begin
                     rsp_status_in = adcmus_pkg::ST_DEFERRED;
                  end else if (conv_busy_ff && cur_user_ff == id_ff) begin
                     rsp_status_in = adcmus_pkg::ST_BUSY;
                  end else begin
                     rsp_status_in = adcmus_pkg::ST_NONE;
                  end
               end
               adcmus_pkg::REQ_START: begin
                  if (id_bad || !refi_ff) begin
                     rsp_status_in = adcmus_pkg::ST_FATAL;
                  end else begin
                     cfg_we = 1'b1;
                     if (pending_ff[id_ff]) begin
                        rsp_status_in = adcmus_pkg::ST_DEFERRED;
                     end else begin
                        valid_in[id_ff] = 1'b0;
                        if (!conv_busy_ff) begin
                           // The queue is always empty while the converter is idle,
                           // so this user is the one that starts.
                           conv_busy_in = 1'b1;
                           cur_user_in = id_ff;
                           rsp_status_in = adcmus_pkg::ST_BUSY;
                           rsp_start_conv_in = 1'b1;
                           rsp_start_user_in = id_ff;
                           rsp_start_channel_in = chan_ff;
                           rsp_start_rate_in = rate_ff;
                        end else begin
                           pending_in[id_ff] = 1'b1;
                           rsp_status_in = adcmus_pkg::ST_DEFERRED;
                        end
                     end
                  end
               end
               default: begin
                  rsp_status_in = adcmus_pkg::ST_FATAL;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
            busy_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff <= 1'b0;
         pending_ff <= '0;
         valid_ff <= '0;
         conv_busy_ff <= 1'b0;
         cur_user_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff <= busy_in;
         pending_ff <= pending_in;
         valid_ff <= valid_in;
         conv_busy_ff <= conv_busy_in;
         cur_user_ff <= cur_user_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_start_conv_ff <= rsp_start_conv_in;
      rsp_start_user_ff <= rsp_start_user_in;
      rsp_start_channel_ff <= rsp_start_channel_in;
      rsp_start_rate_ff <= rsp_start_rate_in;
      rsp_converter_off_ff <= rsp_converter_off_in;
   end

   assign busy = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_start_conv = rsp_start_conv_ff;
   assign rsp_start_user = rsp_start_user_ff;
   assign rsp_start_channel = rsp_start_channel_ff;
   assign rsp_start_rate = rsp_start_rate_ff;
   assign rsp_converter_off = rsp_converter_off_ff;
endmodule
`default_nettype wire

// File: bench/adc_multi_user_request_scheduler_checker.sv
// Checker that predicts and compares every result of the converter request scheduler.
module adc_multi_user_request_scheduler_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire logic [1:0]                      req_type,
   input  wire logic [adcmus_pkg::USER_W-1:0]   req_user_id,
   input  wire logic                            req_reference_internal,
   input  wire logic [adcmus_pkg::CHAN_W-1:0]   req_channel_select,
   input  wire logic [adcmus_pkg::RATE_W-1:0]   req_sample_rate,
   input  wire logic [adcmus_pkg::DATA_W-1:0]   req_conversion_data,
   input  wire logic                            rsp_valid,
   input  wire logic [adcmus_pkg::STATUS_W-1:0] rsp_status,
   input  wire logic [adcmus_pkg::DATA_W-1:0]   rsp_read_value,
   input  wire logic                            rsp_start_conv,
   input  wire logic [adcmus_pkg::USER_W-1:0]   rsp_start_user,
   input  wire logic [adcmus_pkg::CHAN_W-1:0]   rsp_start_channel,
   input  wire logic [adcmus_pkg::RATE_W-1:0]   rsp_start_rate,
   input  wire logic                            rsp_converter_off,
   output int                                   mismatch_count,
   output int                                   outstanding,
   output int                                   checked_count,
   output int                                   launch_count
);

   typedef struct packed {
      adcmus_pkg::status_type          status;
      logic [adcmus_pkg::DATA_W-1:0]   read_value;
      logic                            start_conv;
      logic [adcmus_pkg::USER_W-1:0]   start_user;
      logic [adcmus_pkg::CHAN_W-1:0]   start_channel;
      logic [adcmus_pkg::RATE_W-1:0]   start_rate;
      logic                            converter_off;
   } outcome_type;

   adcmus_pkg::user_mask_type     pending_users;
   adcmus_pkg::user_mask_type     valid_users;
   logic                          conv_active;
   logic [adcmus_pkg::USER_W-1:0] active_user;
   logic [adcmus_pkg::DATA_W-1:0] reading_mem [adcmus_pkg::NUM_USERS];
   logic [adcmus_pkg::CHAN_W-1:0] chan_mem [adcmus_pkg::NUM_USERS];
   logic [adcmus_pkg::RATE_W-1:0] rate_mem [adcmus_pkg::NUM_USERS];

   outcome_type expected_outcomes [$];

   task automatic report_mismatch(input string what);
      $display("[%0t] error: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [adcmus_pkg::DATA_W-1:0] want,
                              input logic [adcmus_pkg::DATA_W-1:0] got);
      if (got !== want) begin
         report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
      end
   endtask

   task automatic launch_lowest_pending(inout outcome_type o,
                                        output logic [adcmus_pkg::USER_W-1:0] chosen);
      logic found;
      found = 1'b0;
      chosen = '0;
      for (int u = 0; u < adcmus_pkg::NUM_USERS; u++) begin
         if (!found && pending_users[u]) begin
            found = 1'b1;
            chosen = u[adcmus_pkg::USER_W-1:0];
            pending_users[u] = 1'b0;
            active_user = chosen;
            conv_active = 1'b1;
            o.start_conv = 1'b1;
            o.start_user = chosen;
            o.start_channel = chan_mem[u];
            o.start_rate = rate_mem[u];
         end
      end
   endtask

   task automatic predict_arbitration(input adcmus_pkg::req_kind_type kind,
                                      input logic [adcmus_pkg::USER_W-1:0] uid,
                                      input logic refi,
                                      input logic [adcmus_pkg::CHAN_W-1:0] chan,
                                      input logic [adcmus_pkg::RATE_W-1:0] rate,
                                      input logic [adcmus_pkg::DATA_W-1:0] data,
                                      output outcome_type o);
      logic [adcmus_pkg::USER_W-1:0] launched;
      o = '0;
      o.status = adcmus_pkg::ST_DONE;
      if (kind == adcmus_pkg::REQ_UNKNOWN) begin
         o.status = adcmus_pkg::ST_FATAL;
      end else if (kind == adcmus_pkg::REQ_CONV_DONE) begin
         if (!conv_active) begin
            o.status = adcmus_pkg::ST_NONE;
         end else begin
            reading_mem[active_user] = data;
            valid_users[active_user] = 1'b1;
            o.status = adcmus_pkg::ST_DONE;
            if (pending_users != '0) begin
               launch_lowest_pending(o, launched);
            end else begin
               conv_active = 1'b0;
               o.converter_off = 1'b1;
            end
         end
      end else if (int'(uid) >= adcmus_pkg::NUM_USERS) begin
         o.status = adcmus_pkg::ST_FATAL;
      end else if (kind == adcmus_pkg::REQ_DATA) begin
         if (valid_users[uid]) begin
            o.status = adcmus_pkg::ST_DONE;
            o.read_value = reading_mem[uid];
            valid_users[uid] = 1'b0;
         end else if (pending_users[uid]) begin
            o.status = adcmus_pkg::ST_DEFERRED;
         end else if (conv_active && active_user == uid) begin
            o.status = adcmus_pkg::ST_BUSY;
         end else begin
            o.status = adcmus_pkg::ST_NONE;
         end
      end else if (!refi) begin
         o.status = adcmus_pkg::ST_FATAL;
      end else begin
         chan_mem[uid] = chan;
         rate_mem[uid] = rate;
         if (pending_users[uid]) begin
            o.status = adcmus_pkg::ST_DEFERRED;
         end else begin
            pending_users[uid] = 1'b1;
            valid_users[uid] = 1'b0;
            o.status = adcmus_pkg::ST_DEFERRED;
            if (!conv_active) begin
               launch_lowest_pending(o, launched);
               if (launched == uid) begin
                  o.status = adcmus_pkg::ST_BUSY;
               end
            end
         end
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      outcome_type got;
      if (reset) begin
         pending_users = '0;
         valid_users = '0;
         conv_active = 1'b0;
         active_user = '0;
         for (int u = 0; u < adcmus_pkg::NUM_USERS; u++) begin
            reading_mem[u] = '0;
            chan_mem[u] = '0;
            rate_mem[u] = '0;
         end
         expected_outcomes.delete();
         mismatch_count = 0;
         outstanding = 0;
         checked_count = 0;
         launch_count = 0;
      end else begin
         if (rsp_valid) begin
            got.status = adcmus_pkg::status_type'(rsp_status);
            got.read_value = rsp_read_value;
            got.start_conv = rsp_start_conv;
            got.start_user = rsp_start_user;
            got.start_channel = rsp_start_channel;
            got.start_rate = rsp_start_rate;
            got.converter_off = rsp_converter_off;
            if (expected_outcomes.size() == 0) begin
               report_mismatch("result arrived with no transaction waiting for it");
            end else begin
               want = expected_outcomes.pop_front();
               check_field("status", adcmus_pkg::DATA_W'(want.status),
                           adcmus_pkg::DATA_W'(got.status));
               check_field("read_value", want.read_value, got.read_value);
               check_field("start_conv", adcmus_pkg::DATA_W'(want.start_conv),
                           adcmus_pkg::DATA_W'(got.start_conv));
               check_field("start_user", adcmus_pkg::DATA_W'(want.start_user),
                           adcmus_pkg::DATA_W'(got.start_user));
               check_field("start_channel", adcmus_pkg::DATA_W'(want.start_channel),
                           adcmus_pkg::DATA_W'(got.start_channel));
               check_field("start_rate", adcmus_pkg::DATA_W'(want.start_rate),
                           adcmus_pkg::DATA_W'(got.start_rate));
               check_field("converter_off", adcmus_pkg::DATA_W'(want.converter_off),
                           adcmus_pkg::DATA_W'(got.converter_off));
               checked_count++;
               if (want.start_conv) begin
                  launch_count++;
               end
            end
         end
         if (start && !busy) begin
            predict_arbitration(adcmus_pkg::req_kind_type'(req_type), req_user_id,
                                req_reference_internal, req_channel_select,
                                req_sample_rate, req_conversion_data, want);
            expected_outcomes.push_back(want);
         end
         outstanding = expected_outcomes.size();
      end
   end

endmodule

// File: bench/tb_adc_multi_user_request_scheduler_top.sv
// Testbench top: clock, reset and transaction stimulus for the converter request scheduler.
module tb_adc_multi_user_request_scheduler_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 470;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [1:0]                      req_type;
   logic [adcmus_pkg::USER_W-1:0]   req_user_id;
   logic                            req_reference_internal;
   logic [adcmus_pkg::CHAN_W-1:0]   req_channel_select;
   logic [adcmus_pkg::RATE_W-1:0]   req_sample_rate;
   logic [adcmus_pkg::DATA_W-1:0]   req_conversion_data;
   logic                            rsp_valid;
   logic [adcmus_pkg::STATUS_W-1:0] rsp_status;
   logic [adcmus_pkg::DATA_W-1:0]   rsp_read_value;
   logic                            rsp_start_conv;
   logic [adcmus_pkg::USER_W-1:0]   rsp_start_user;
   logic [adcmus_pkg::CHAN_W-1:0]   rsp_start_channel;
   logic [adcmus_pkg::RATE_W-1:0]   rsp_start_rate;
   logic                            rsp_converter_off;

   int mismatch_count;
   int outstanding;
   int checked_count;
   int launch_count;
   int idle_pct = 0;
   int sent_count = 0;
   int cycle_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   adc_multi_user_request_scheduler_top uut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_type               (req_type),
      .req_user_id            (req_user_id),
      .req_reference_internal (req_reference_internal),
      .req_channel_select     (req_channel_select),
      .req_sample_rate        (req_sample_rate),
      .req_conversion_data    (req_conversion_data),
      .rsp_valid              (rsp_valid),
      .rsp_status             (rsp_status),
      .rsp_read_value         (rsp_read_value),
      .rsp_start_conv         (rsp_start_conv),
      .rsp_start_user         (rsp_start_user),
      .rsp_start_channel      (rsp_start_channel),
      .rsp_start_rate         (rsp_start_rate),
      .rsp_converter_off      (rsp_converter_off)
   );

   adc_multi_user_request_scheduler_checker result_checker (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_type               (req_type),
      .req_user_id            (req_user_id),
      .req_reference_internal (req_reference_internal),
      .req_channel_select     (req_channel_select),
      .req_sample_rate        (req_sample_rate),
      .req_conversion_data    (req_conversion_data),
      .rsp_valid              (rsp_valid),
      .rsp_status             (rsp_status),
      .rsp_read_value         (rsp_read_value),
      .rsp_start_conv         (rsp_start_conv),
      .rsp_start_user         (rsp_start_user),
      .rsp_start_channel      (rsp_start_channel),
      .rsp_start_rate         (rsp_start_rate),
      .rsp_converter_off      (rsp_converter_off),
      .mismatch_count         (mismatch_count),
      .outstanding            (outstanding),
      .checked_count          (checked_count),
      .launch_count           (launch_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_transaction(input adcmus_pkg::req_kind_type kind,
                                   input logic [adcmus_pkg::USER_W-1:0] uid,
                                   input logic refi, input logic [adcmus_pkg::CHAN_W-1:0] chan,
                                   input logic [adcmus_pkg::RATE_W-1:0] rate,
                                   input logic [adcmus_pkg::DATA_W-1:0] data);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= kind;
      req_user_id <= uid;
      req_reference_internal <= refi;
      req_channel_select <= chan;
      req_sample_rate <= rate;
      req_conversion_data <= data;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      sent_count++;
   endtask

   task automatic send_random_transaction();
      int pick;
      adcmus_pkg::req_kind_type kind;
      pick = $urandom_range(99);
      if (pick < 36) begin
         kind = adcmus_pkg::REQ_START;
      end else if (pick < 66) begin
         kind = adcmus_pkg::REQ_DATA;
      end else if (pick < 95) begin
         kind = adcmus_pkg::REQ_CONV_DONE;
      end else begin
         kind = adcmus_pkg::REQ_UNKNOWN;
      end
      send_transaction(kind, adcmus_pkg::USER_W'($urandom_range(adcmus_pkg::NUM_USERS - 1)),
                       $urandom_range(99) >= 8,
                       adcmus_pkg::CHAN_W'($urandom_range(255)),
                       adcmus_pkg::RATE_W'($urandom_range(7)),
                       adcmus_pkg::DATA_W'($urandom_range(65535)));
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_type <= adcmus_pkg::REQ_START;
      req_user_id <= '0;
      req_reference_internal <= 1'b0;
      req_channel_select <= '0;
      req_sample_rate <= '0;
      req_conversion_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Idle queries, unknown kind and an external reference before anything is queued.
      send_transaction(adcmus_pkg::REQ_DATA, 3'd0, 1'b1, 8'h00, 3'd0, 16'h0000);
      send_transaction(adcmus_pkg::REQ_CONV_DONE, 3'd0, 1'b1, 8'h00, 3'd0, 16'hFFFF);
      send_transaction(adcmus_pkg::REQ_UNKNOWN, 3'd7, 1'b1, 8'hFF, 3'd7, 16'hFFFF);
      send_transaction(adcmus_pkg::REQ_START, 3'd2, 1'b0, 8'h3C, 3'd5, 16'h0000);
      // Start on an idle converter, then queue and repeat starts while it converts.
      send_transaction(adcmus_pkg::REQ_START, 3'd5, 1'b1, 8'hFF, 3'd7, 16'h0000);
      send_transaction(adcmus_pkg::REQ_START, 3'd5, 1'b1, 8'h81, 3'd1, 16'h0000);
      send_transaction(adcmus_pkg::REQ_START, 3'd5, 1'b1, 8'h42, 3'd6, 16'h0000);
      send_transaction(adcmus_pkg::REQ_START, 3'd0, 1'b1, 8'h00, 3'd0, 16'h0000);
      send_transaction(adcmus_pkg::REQ_DATA, 3'd5, 1'b1, 8'h00, 3'd0, 16'h0000);
      send_transaction(adcmus_pkg::REQ_DATA, 3'd3, 1'b1, 8'h00, 3'd0, 16'h0000);
      // Completions hand the converter to the lowest waiting user, then switch it off.
      send_transaction(adcmus_pkg::REQ_CONV_DONE, 3'd0, 1'b1, 8'h00, 3'd0, 16'hFFFF);
      send_transaction(adcmus_pkg::REQ_DATA, 3'd5, 1'b1, 8'h00, 3'd0, 16'h0000);
      send_transaction(adcmus_pkg::REQ_DATA, 3'd0, 1'b1, 8'h00, 3'd0, 16'h0000);
      send_transaction(adcmus_pkg::REQ_CONV_DONE, 3'd0, 1'b1, 8'h00, 3'd0, 16'h0000);
      send_transaction(adcmus_pkg::REQ_CONV_DONE, 3'd0, 1'b1, 8'h00, 3'd0, 16'h1234);
      send_transaction(adcmus_pkg::REQ_DATA, 3'd0, 1'b1, 8'h00, 3'd0, 16'h0000);
      send_transaction(adcmus_pkg::REQ_DATA, 3'd0, 1'b1, 8'h00, 3'd0, 16'h0000);
      send_transaction(adcmus_pkg::REQ_DATA, 3'd5, 1'b1, 8'h00, 3'd0, 16'h0000);
      send_transaction(adcmus_pkg::REQ_DATA, 3'd7, 1'b1, 8'h00, 3'd0, 16'h0000);
      send_transaction(adcmus_pkg::REQ_START, 3'd7, 1'b1, 8'hA5, 3'd3, 16'h0000);
      send_transaction(adcmus_pkg::REQ_START, 3'd7, 1'b0, 8'h5A, 3'd4, 16'h0000);
      send_transaction(adcmus_pkg::REQ_CONV_DONE, 3'd4, 1'b1, 8'h00, 3'd0, 16'h8000);
      send_transaction(adcmus_pkg::REQ_DATA, 3'd7, 1'b1, 8'h00, 3'd0, 16'h0000);

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 6 : (phase == 1) ? 61 : 0;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random_transaction();
         end
      end
      start <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("Run summary: %0d transactions sent under three pacing phases, %0d results",
               sent_count, checked_count);
      $display("checked, %0d conversions launched.", launch_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
